/* rtl/edc_pkg.sv */
// Shared widths, constants and stage payload types for the epoch-to-calendar pipeline.
package edc_pkg;

  localparam int SecW    = 31;
  localparam int DayW    = 15;
  localparam int RemW    = 17;
  localparam int CycW    = 5;
  localparam int CycDayW = 11;
  localparam int HourRemW = 12;

  // seconds per day = 2^7 * DayOdd
  localparam int          DaySecShift = 7;
  localparam logic [9:0]  DayOdd      = 10'd675;
  localparam logic [24:0] DayRecip    = 25'd25451658;  // floor(2^34 / 675)
  localparam int          DayRecipSh  = 34;

  // four-year cycles counted from 1968, a leap year
  localparam logic [14:0] EpochOfs    = 15'd731;
  localparam logic [10:0] CycDays     = 11'd1461;
  localparam logic [15:0] CycRecip    = 16'd45933;     // floor(2^26 / 1461)
  localparam int          CycRecipSh  = 26;
  localparam logic [10:0] Yr1Start    = 11'd366;
  localparam logic [10:0] Yr2Start    = 11'd731;
  localparam logic [10:0] Yr3Start    = 11'd1096;
  localparam logic [6:0]  CycYearOfs  = 7'd2;

  localparam logic [14:0] WdayOfs     = 15'd4;
  localparam logic [2:0]  DaysPerWeek = 3'd7;
  localparam logic [15:0] WeekRecip   = 16'd37449;     // floor(2^18 / 7)
  localparam int          WeekRecipSh = 18;

  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [12:0] HourRecip   = 13'd4660;      // floor(2^20 / 225)
  localparam int          HourRecipSh = 20;

  localparam logic [5:0]  SecsPerMin  = 6'd60;
  localparam logic [12:0] MinRecip    = 13'd4369;      // floor(2^16 / 15)
  localparam int          MinRecipSh  = 16;

  typedef struct packed {
    logic [DayW-1:0] days;
    logic [RemW-1:0] rem;
  } day_rem_t;

  typedef struct packed {
    logic [CycW-1:0]     cyc;
    logic [CycDayW-1:0]  cyc_day;
    logic [2:0]          wday;
    logic [4:0]          hour;
    logic [HourRemW-1:0] hour_rem;
  } split_t;

endpackage

/* rtl/edc_day_div.sv */
// Three-stage divide of the second count by 86400 into days and seconds of day.
module edc_day_div import edc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [SecW-1:0] secs_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output day_rem_t        out_o
);

  localparam int Stages = 3;
  localparam int XW     = SecW - DaySecShift;
  localparam int ProdW  = XW + 25;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] adv;

  always_comb begin
    adv[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage 0: reciprocal multiply
  logic [ProdW-1:0]       prod_d;
  logic [XW-1:0]          s0_x_q;
  logic [DaySecShift-1:0] s0_lo_q;
  logic [DayW-1:0]        s0_qest_q;

  assign prod_d = ProdW'(secs_i[SecW-1:DaySecShift]) * ProdW'(DayRecip);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_x_q    <= secs_i[SecW-1:DaySecShift];
      s0_lo_q   <= secs_i[DaySecShift-1:0];
      s0_qest_q <= prod_d[DayRecipSh +: DayW];
    end
  end

  // stage 1: remainder of the estimate
  logic [XW-1:0]          qm_d;
  logic [XW-1:0]          r_d;
  logic [DayW-1:0]        s1_q_q;
  logic [10:0]            s1_r_q;
  logic [DaySecShift-1:0] s1_lo_q;

  assign qm_d = XW'(s0_qest_q) * XW'(DayOdd);
  assign r_d  = s0_x_q - qm_d;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_q_q  <= s0_qest_q;
      s1_r_q  <= r_d[10:0];
      s1_lo_q <= s0_lo_q;
    end
  end

  // stage 2: correct by one
  logic       fix_d;
  logic [9:0] rh_d;
  day_rem_t   s2_q;

  assign fix_d = s1_r_q >= 11'(DayOdd);
  assign rh_d  = fix_d ? 10'(s1_r_q - 11'(DayOdd)) : s1_r_q[9:0];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_q.days <= fix_d ? s1_q_q + DayW'(1) : s1_q_q;
      s2_q.rem  <= {rh_d, s1_lo_q};
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[Stages-1];
  assign out_o       = s2_q;

endmodule

/* rtl/edc_split.sv */
// Three-stage split of days into four-year cycles and weekday, and seconds into hours.
module edc_split import edc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  day_rem_t in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output split_t   out_o
);

  localparam int Stages = 3;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] adv;

  always_comb begin
    adv[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage 0: three reciprocal multiplies
  logic [DayW-1:0] dp_d, dw_d;
  logic [30:0]     py_d, pw_d;
  logic [25:0]     ph_d;

  logic [DayW-1:0] s0_dp_q, s0_dw_q;
  logic [RemW-1:0] s0_rem_q;
  logic [CycW-1:0] s0_c_q;
  logic [12:0]     s0_w_q;
  logic [4:0]      s0_h_q;

  assign dp_d = in_i.days + EpochOfs;
  assign dw_d = in_i.days + WdayOfs;
  assign py_d = 31'(dp_d) * 31'(CycRecip);
  assign pw_d = 31'(dw_d) * 31'(WeekRecip);
  assign ph_d = 26'(in_i.rem[RemW-1:4]) * 26'(HourRecip);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_dp_q  <= dp_d;
      s0_dw_q  <= dw_d;
      s0_rem_q <= in_i.rem;
      s0_c_q   <= py_d[CycRecipSh +: CycW];
      s0_w_q   <= pw_d[WeekRecipSh +: 13];
      s0_h_q   <= ph_d[HourRecipSh +: 5];
    end
  end

  // stage 1: remainders of the estimates
  logic [15:0]     ry_d, rw_d;
  logic [RemW-1:0] rh_d;

  logic [CycW-1:0] s1_c_q;
  logic [11:0]     s1_ry_q;
  logic [12:0]     s1_w_q;
  logic [3:0]      s1_rw_q;
  logic [4:0]      s1_h_q;
  logic [12:0]     s1_rh_q;

  assign ry_d = 16'(s0_dp_q) - 16'(s0_c_q) * 16'(CycDays);
  assign rw_d = 16'(s0_dw_q) - 16'(s0_w_q) * 16'(DaysPerWeek);
  assign rh_d = s0_rem_q - RemW'(s0_h_q) * RemW'(SecsPerHour);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_c_q  <= s0_c_q;
      s1_ry_q <= ry_d[11:0];
      s1_w_q  <= s0_w_q;
      s1_rw_q <= rw_d[3:0];
      s1_h_q  <= s0_h_q;
      s1_rh_q <= rh_d[12:0];
    end
  end

  // stage 2: correct each by one
  logic   fix_y_d, fix_w_d, fix_h_d;
  split_t s2_q;

  assign fix_y_d = s1_ry_q >= 12'(CycDays);
  assign fix_w_d = s1_rw_q >= 4'(DaysPerWeek);
  assign fix_h_d = s1_rh_q >= 13'(SecsPerHour);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_q.cyc      <= fix_y_d ? s1_c_q + CycW'(1) : s1_c_q;
      s2_q.cyc_day  <= fix_y_d ? 11'(s1_ry_q - 12'(CycDays)) : s1_ry_q[10:0];
      s2_q.wday     <= fix_w_d ? 3'(s1_rw_q - 4'(DaysPerWeek)) : s1_rw_q[2:0];
      s2_q.hour     <= fix_h_d ? s1_h_q + 5'd1 : s1_h_q;
      s2_q.hour_rem <= fix_h_d ? 12'(s1_rh_q - 13'(SecsPerHour)) : s1_rh_q[11:0];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[Stages-1];
  assign out_o       = s2_q;

endmodule

/* rtl/edc_fields.sv */
// Three-stage finish: year and day of year within the cycle, minute and second split.
module edc_fields import edc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  split_t     in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] years_o,
  output logic [8:0] yday_o,
  output logic [2:0] wday_o,
  output logic [4:0] hour_o,
  output logic [5:0] minute_o,
  output logic [5:0] second_o
);

  localparam int Stages = 3;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] adv;

  always_comb begin
    adv[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (adv[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage 0: year within the cycle, minute estimate
  logic [1:0]          k_d;
  logic [10:0]         start_d;
  logic [10:0]         doy_d;
  logic [22:0]         pm_d;

  logic [6:0]          s0_years_q;
  logic [8:0]          s0_yday_q;
  logic [2:0]          s0_wday_q;
  logic [4:0]          s0_hour_q;
  logic [HourRemW-1:0] s0_rsec_q;
  logic [5:0]          s0_m_q;

  always_comb begin
    if (in_i.cyc_day >= Yr3Start) begin
      k_d = 2'd3;
      start_d = Yr3Start;
    end else if (in_i.cyc_day >= Yr2Start) begin
      k_d = 2'd2;
      start_d = Yr2Start;
    end else if (in_i.cyc_day >= Yr1Start) begin
      k_d = 2'd1;
      start_d = Yr1Start;
    end else begin
      k_d = 2'd0;
      start_d = '0;
    end
  end

  assign doy_d = in_i.cyc_day - start_d + 11'd1;
  assign pm_d  = 23'(in_i.hour_rem[HourRemW-1:2]) * 23'(MinRecip);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_years_q <= {in_i.cyc, k_d} - CycYearOfs;
      s0_yday_q  <= doy_d[8:0];
      s0_wday_q  <= in_i.wday;
      s0_hour_q  <= in_i.hour;
      s0_rsec_q  <= in_i.hour_rem;
      s0_m_q     <= pm_d[MinRecipSh +: 6];
    end
  end

  // stage 1: second remainder of the minute estimate
  logic [HourRemW-1:0] rs_d;
  logic [6:0] s1_years_q;
  logic [8:0] s1_yday_q;
  logic [2:0] s1_wday_q;
  logic [4:0] s1_hour_q;
  logic [5:0] s1_m_q;
  logic [6:0] s1_rs_q;

  assign rs_d = s0_rsec_q - HourRemW'(s0_m_q) * HourRemW'(SecsPerMin);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_years_q <= s0_years_q;
      s1_yday_q  <= s0_yday_q;
      s1_wday_q  <= s0_wday_q;
      s1_hour_q  <= s0_hour_q;
      s1_m_q     <= s0_m_q;
      s1_rs_q    <= rs_d[6:0];
    end
  end

  // stage 2: correct by one, output register
  logic fix_m_d;
  logic [6:0] s2_years_q;
  logic [8:0] s2_yday_q;
  logic [2:0] s2_wday_q;
  logic [4:0] s2_hour_q;
  logic [5:0] s2_min_q;
  logic [5:0] s2_sec_q;

  assign fix_m_d = s1_rs_q >= 7'(SecsPerMin);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_years_q <= s1_years_q;
      s2_yday_q  <= s1_yday_q;
      s2_wday_q  <= s1_wday_q;
      s2_hour_q  <= s1_hour_q;
      s2_min_q   <= fix_m_d ? s1_m_q + 6'd1 : s1_m_q;
      s2_sec_q   <= fix_m_d ? 6'(s1_rs_q - 7'(SecsPerMin)) : s1_rs_q[5:0];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[Stages-1];
  assign years_o     = s2_years_q;
  assign yday_o      = s2_yday_q;
  assign wday_o      = s2_wday_q;
  assign hour_o      = s2_hour_q;
  assign minute_o    = s2_min_q;
  assign second_o    = s2_sec_q;

endmodule

/* rtl/epoch_seconds_to_calendar.sv */
// Top level: converts seconds since 1970 into year, day of year, weekday and time of day.
// Nine register stages lie between input accept and output valid.
// Throughput: one item per cycle; every stage holds one item and advances when the next
// stage is empty or moving, so a stalled output backs up without losing bubbles' space.
// Reset clears only the stage valid bits; data registers are not reset.
module epoch_seconds_to_calendar import edc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [SecW-1:0] epoch_seconds_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [6:0]      years_since_1970_o,
  output logic [8:0]      day_of_year_o,
  output logic [2:0]      weekday_o,
  output logic [4:0]      hour_of_day_o,
  output logic [5:0]      minute_of_hour_o,
  output logic [5:0]      second_of_minute_o
);

  logic     dr_valid, dr_ready;
  day_rem_t dr;
  logic     sp_valid, sp_ready;
  split_t   sp;

  edc_day_div u_day_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .secs_i      (epoch_seconds_i),
    .out_valid_o (dr_valid),
    .out_ready_i (dr_ready),
    .out_o       (dr)
  );

  edc_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dr_valid),
    .in_ready_o  (dr_ready),
    .in_i        (dr),
    .out_valid_o (sp_valid),
    .out_ready_i (sp_ready),
    .out_o       (sp)
  );

  edc_fields u_fields (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sp_valid),
    .in_ready_o  (sp_ready),
    .in_i        (sp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .years_o     (years_since_1970_o),
    .yday_o      (day_of_year_o),
    .wday_o      (weekday_o),
    .hour_o      (hour_of_day_o),
    .minute_o    (minute_of_hour_o),
    .second_o    (second_of_minute_o)
  );

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_of_day_o < 5'd24) && (minute_of_hour_o < 6'd60) &&
                    (second_of_minute_o < 6'd60))
    else $error("time of day out of range");

  a_wday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> weekday_o < 3'd7)
    else $error("weekday out of range");

  a_yday_leap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (day_of_year_o != 9'd0) &&
                    ((day_of_year_o < 9'd366) ||
                     ((day_of_year_o == 9'd366) && (years_since_1970_o[1:0] == 2'd2))))
    else $error("day of year not valid for this year");

  a_mid_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dr_valid |-> dr.rem < 17'd86400)
    else $error("second of day out of range");

endmodule

/* tb/calendar_checker.sv */
// Checker for the epoch-to-calendar block: predicts each date and compares results.
module calendar_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [30:0] epoch_seconds_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [6:0]  years_since_1970_i,
  input  logic [8:0]  day_of_year_i,
  input  logic [2:0]  weekday_i,
  input  logic [4:0]  hour_of_day_i,
  input  logic [5:0]  minute_of_hour_i,
  input  logic [5:0]  second_of_minute_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int unsigned SecsPerDay  = 24 * 60 * 60;
  localparam int unsigned SecsPerHour = 60 * 60;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned LeapPeriod  = 4;
  localparam int unsigned DaysPerWeek = 7;
  localparam int          MaxReports  = 10;

  typedef struct packed {
    logic [6:0] years;
    logic [8:0] yday;
    logic [2:0] wday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } calendar_t;

  calendar_t expected_dates[$];

  function automatic calendar_t calendar_from_seconds(logic [30:0] secs);
    int unsigned days;
    int unsigned rem;
    int unsigned left;
    int unsigned yr;
    int unsigned len;
    calendar_t   c;
    days = secs / SecsPerDay;
    rem  = secs % SecsPerDay;
    left = days;
    yr   = 0;
    len  = DaysPerYear + (((yr + 2) % LeapPeriod == 0) ? 1 : 0);
    while (left >= len && yr < 127) begin
      left -= len;
      yr++;
      len = DaysPerYear + (((yr + 2) % LeapPeriod == 0) ? 1 : 0);
    end
    c.years  = 7'(yr);
    c.yday   = 9'(left + 1);
    c.wday   = 3'((days + 4) % DaysPerWeek);
    c.hour   = 5'(rem / SecsPerHour);
    c.minute = 6'((rem % SecsPerHour) / SecsPerMin);
    c.second = 6'(rem % SecsPerMin);
    return c;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  always @(posedge clk_i) begin
    calendar_t want;
    calendar_t got;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        got = {years_since_1970_i, day_of_year_i, weekday_i, hour_of_day_i,
               minute_of_hour_i, second_of_minute_i};
        if (expected_dates.size() == 0) begin
          if (fail_count_o < MaxReports)
            $display("ERROR: unexpected result yr=%0d yday=%0d wd=%0d %0d:%0d:%0d",
                     got.years, got.yday, got.wday, got.hour, got.minute, got.second);
          fail_count_o++;
        end else begin
          want = expected_dates.pop_front();
          checked_o++;
          if (got !== want) begin
            if (fail_count_o < MaxReports)
              $display("ERROR: exp yr=%0d yday=%0d wd=%0d %0d:%0d:%0d, got yr=%0d yday=%0d wd=%0d %0d:%0d:%0d",
                       want.years, want.yday, want.wday, want.hour, want.minute, want.second,
                       got.years, got.yday, got.wday, got.hour, got.minute, got.second);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_dates.push_back(calendar_from_seconds(epoch_seconds_i));
      pending_o = expected_dates.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Testbench top: clock, reset, date stimulus, output backpressure and verdict.
module testbench;
  import edc_pkg::*;

  localparam int          SecsPerDay     = 24 * 60 * 60;
  localparam int          DaysPerYear    = 365;
  localparam longint      MaxSeconds     = 64'h7fff_ffff;
  localparam int          HoldOffCycles  = 80;
  localparam int          WatchdogLimit  = 2000;
  localparam int          DrainCycles    = 20;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [SecW-1:0] epoch_seconds = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [6:0]      years_since_1970;
  logic [8:0]      day_of_year;
  logic [2:0]      weekday;
  logic [4:0]      hour_of_day;
  logic [5:0]      minute_of_hour;
  logic [5:0]      second_of_minute;

  int fail_count;
  int pending;
  int checked;
  int sent = 0;
  int stall_cycles = 0;
  bit rx_steady = 1'b1;
  bit hold_off_req = 1'b0;

  always #5 clk_i = ~clk_i;

  epoch_seconds_to_calendar dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .epoch_seconds_i    (epoch_seconds),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .years_since_1970_o (years_since_1970),
    .day_of_year_o      (day_of_year),
    .weekday_o          (weekday),
    .hour_of_day_o      (hour_of_day),
    .minute_of_hour_o   (minute_of_hour),
    .second_of_minute_o (second_of_minute)
  );

  calendar_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .epoch_seconds_i    (epoch_seconds),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .years_since_1970_i (years_since_1970),
    .day_of_year_i      (day_of_year),
    .weekday_i          (weekday),
    .hour_of_day_i      (hour_of_day),
    .minute_of_hour_i   (minute_of_hour),
    .second_of_minute_i (second_of_minute),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint first_day_of(int yr);
    longint d;
    d = 0;
    for (int y = 0; y < yr; y++)
      d += DaysPerYear + (((y + 2) % 4 == 0) ? 1 : 0);
    return d;
  endfunction

  function automatic logic [SecW-1:0] clip_seconds(longint s);
    if (s < 0) return '0;
    if (s > MaxSeconds) return SecW'(MaxSeconds);
    return SecW'(s);
  endfunction

  function automatic logic [SecW-1:0] random_seconds();
    int     r;
    longint s;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      s = $urandom & 32'h7fff_ffff;
    end else if (r < 70) begin
      s = first_day_of($urandom_range(1, 68)) * SecsPerDay
          + longint'($urandom_range(0, 2 * SecsPerDay)) - SecsPerDay;
    end else if (r < 90) begin
      s = longint'($urandom_range(0, 24855)) * SecsPerDay;
      case ($urandom_range(0, 5))
        0: s += 0;
        1: s += 1;
        2: s += SecsPerDay - 1;
        3: s += 3599;
        4: s += 3600;
        default: s += $urandom_range(0, SecsPerDay - 1);
      endcase
    end else begin
      s = $urandom_range(0, 1000000);
    end
    return clip_seconds(s);
  endfunction

  task automatic send_item(logic [SecW-1:0] secs, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid      <= 1'b0;
      epoch_seconds <= SecW'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls, steady stretches, one long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else if (!rx_steady && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("Timeout: no item moved for %0d cycles", WatchdogLimit);
        $display("** epoch_seconds_to_calendar: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [SecW-1:0] directed[$];
    longint          leap72;
    longint          y2k;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    leap72 = first_day_of(2);
    y2k    = first_day_of(30);
    directed = '{31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
                 SecW'(MaxSeconds), SecW'(MaxSeconds - 1), 31'h5555_5555, 31'h2aaa_aaaa,
                 SecW'(longint'(DaysPerYear) * SecsPerDay - 1),
                 SecW'(leap72 * SecsPerDay),
                 SecW'((leap72 + 59) * SecsPerDay + 43200),
                 SecW'((leap72 + 365) * SecsPerDay),
                 SecW'((leap72 + 365) * SecsPerDay + SecsPerDay - 1),
                 SecW'((leap72 + 366) * SecsPerDay),
                 SecW'((y2k + 365) * SecsPerDay + 86399),
                 SecW'((y2k + 366) * SecsPerDay),
                 SecW'(first_day_of(68) * SecsPerDay),
                 SecW'(first_day_of(68) * SecsPerDay - 1),
                 SecW'(7 * SecsPerDay)};
    foreach (directed[i]) send_item(directed[i], 0);
    wait_drained();

    // steady stretch, no idling on either side
    repeat (150) send_item(random_seconds(), 0);

    // long receiver hold-off while the sender keeps offering
    hold_off_req = 1'b1;
    repeat (40) send_item(random_seconds(), 0);
    wait_drained();

    rx_steady = 1'b0;
    repeat (600) send_item(random_seconds(), pick_gap());
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d items (%0d directed: field extremes, leap-year ends, 2038 limit),",
             sent, directed.size());
    $display("%0d results checked under random gaps, steady runs and an %0d-cycle hold-off.",
             checked, HoldOffCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("** epoch_seconds_to_calendar: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("** epoch_seconds_to_calendar: FAILED **");
    end
    $finish;
  end

endmodule
